[src/clis_pkg.sv]
// Package for the character LCD interface sequencer.
// Holds payload structs, opcode and register codes, bus constants and the
// controller/datapath command and status types. No dependencies.
package clis_pkg;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] value;
      logic [2:0] line;
      logic [7:0] column;
   } req_type;

   typedef struct packed {
      logic        reg_select;
      logic        enable;
      logic [7:0]  bus_value;
      logic [15:0] hold_us;
      logic        last;
   } rsp_type;

   localparam logic [2:0] OP_CMD      = 3'd0;
   localparam logic [2:0] OP_CHAR     = 3'd1;
   localparam logic [2:0] OP_CURSOR   = 3'd2;
   localparam logic [2:0] OP_INIT     = 3'd3;
   localparam logic [2:0] OP_CLEAR    = 3'd4;
   localparam logic [2:0] OP_SHUTDOWN = 3'd5;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_FOUR_BIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FSET_8BIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FSET_4BIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DISP      = 3'd4;

   localparam logic [7:0] RST_FSET_8BIT = 8'h38;
   localparam logic [7:0] RST_FSET_4BIT = 8'h28;
   localparam logic [7:0] RST_ENTRY     = 8'h06;
   localparam logic [7:0] RST_DISP      = 8'h0C;

   localparam logic [7:0] WAKE_BYTE  = 8'h30;
   localparam logic [7:0] WAKE_NIB   = 8'h03;
   localparam logic [7:0] NIB_4BIT   = 8'h02;
   localparam logic [7:0] CLEAR_CMD  = 8'h01;
   localparam logic [7:0] OFF_CMD    = 8'h08;
   localparam logic [3:0] NIB_MASK   = 4'hF;

   localparam logic [2:0] LINE_1 = 3'd1;
   localparam logic [2:0] LINE_2 = 3'd2;
   localparam logic [2:0] LINE_3 = 3'd3;
   localparam logic [2:0] LINE_4 = 3'd4;
   localparam logic [7:0] BASE_1 = 8'h80;
   localparam logic [7:0] BASE_2 = 8'hC0;
   localparam logic [7:0] BASE_3 = 8'h90;
   localparam logic [7:0] BASE_4 = 8'hD0;

   localparam logic [15:0] HOLD_STROBE = 16'd1;
   localparam logic [15:0] HOLD_POWER  = 16'd40000;
   localparam logic [15:0] HOLD_SETTLE = 16'd40;
   localparam logic [15:0] HOLD_LONG   = 16'd2000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_WAIT,
      S_WAKE,
      S_NIB,
      S_FSET,
      S_ENTRY,
      S_DISP,
      S_CLEAR,
      S_USER,
      S_OFF
   } state_type;

   typedef enum logic [3:0] {
      SRC_REQ,
      SRC_WAIT,
      SRC_WAKE8,
      SRC_WAKE4,
      SRC_NIB2,
      SRC_FSET,
      SRC_ENTRY,
      SRC_DISP,
      SRC_CLEAR,
      SRC_OFF
   } src_type;

   typedef struct packed {
      logic       capture;
      logic       emit;
      src_type    src;
      logic [1:0] phase;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       line_ok;
      logic       mode4;
      logic       out_free;
   } sts_type;

endpackage

[src/clis_ctrl.sv]
// Controller state machine of the character LCD interface sequencer.
// Walks each request through its pin-state steps. Depends on clis_pkg.
module clis_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  clis_pkg::sts_type sts,
   output clis_pkg::cmd_type cmd
);
   import clis_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] wake_ff, wake_in;
   logic       shut_ff, shut_in;
   logic [1:0] last_phase;
   logic       step_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 2'd0;
         wake_ff  <= 2'd0;
         shut_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         wake_ff  <= wake_in;
         shut_ff  <= shut_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      wake_in     = wake_ff;
      shut_in     = shut_ff;
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.emit    = 1'b0;
      cmd.src     = SRC_REQ;
      cmd.phase   = phase_ff;
      cmd.last    = 1'b0;
      last_phase  = sts.mode4 ? 2'd3 : 2'd1;

      case (state_ff)
         S_WAIT:   begin cmd.src = SRC_WAIT;  last_phase = 2'd0; end
         S_WAKE:   begin
            cmd.src = sts.mode4 ? SRC_WAKE4 : SRC_WAKE8;
            if (sts.mode4) begin
               last_phase = 2'd1;
            end
         end
         S_NIB:    begin cmd.src = SRC_NIB2;  last_phase = 2'd1; end
         S_FSET:   cmd.src = SRC_FSET;
         S_ENTRY:  cmd.src = SRC_ENTRY;
         S_DISP:   cmd.src = SRC_DISP;
         S_CLEAR:  cmd.src = SRC_CLEAR;
         S_OFF:    cmd.src = SRC_OFF;
         default:  cmd.src = SRC_REQ;
      endcase

      step_done = sts.out_free && (phase_ff == last_phase);

      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            phase_in = 2'd0;
            wake_in  = 2'd0;
            shut_in  = 1'b0;
            case (sts.op)
               OP_CMD, OP_CHAR: state_in = S_USER;
               OP_CURSOR:       state_in = sts.line_ok ? S_USER : S_IDLE;
               OP_INIT:         state_in = S_WAIT;
               OP_CLEAR:        state_in = S_CLEAR;
               OP_SHUTDOWN: begin
                  state_in = S_CLEAR;
                  shut_in  = 1'b1;
               end
               default:         state_in = S_IDLE;
            endcase
         end
         default: begin
            cmd.emit = sts.out_free;
            if (sts.out_free) begin
               phase_in = phase_ff + 2'd1;
            end
            case (state_ff)
               S_USER:  cmd.last = phase_ff == last_phase;
               S_CLEAR: cmd.last = (phase_ff == last_phase) && !shut_ff;
               S_OFF:   cmd.last = phase_ff == last_phase;
               default: cmd.last = 1'b0;
            endcase
            if (step_done) begin
               phase_in = 2'd0;
               case (state_ff)
                  S_WAIT: state_in = S_WAKE;
                  S_WAKE: begin
                     if (wake_ff == 2'd2) begin
                        state_in = sts.mode4 ? S_NIB : S_FSET;
                     end else begin
                        wake_in = wake_ff + 2'd1;
                     end
                  end
                  S_NIB:   state_in = S_FSET;
                  S_FSET:  state_in = S_ENTRY;
                  S_ENTRY: state_in = S_DISP;
                  S_DISP:  state_in = S_CLEAR;
                  S_CLEAR: state_in = shut_ff ? S_OFF : S_IDLE;
                  default: state_in = S_IDLE;
               endcase
            end
         end
      endcase
   end

endmodule

[src/clis_dp.sv]
// Datapath of the character LCD interface sequencer.
// Holds the setup registers, the captured request and the result register.
// Depends on clis_pkg.
module clis_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [clis_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [clis_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  clis_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output clis_pkg::rsp_type                   rsp_payload,
   input  clis_pkg::cmd_type                   cmd,
   output clis_pkg::sts_type                   sts
);
   import clis_pkg::*;

   logic       four_ff;
   logic [7:0] fset8_ff, fset4_ff, entry_ff, disp_ff;
   logic [2:0] op_ff;
   logic       line_ok_ff, line_ok_in;
   logic       mode4_ff;
   logic       rs_ff;
   logic [7:0] byte_ff, byte_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff, rsp_in;
   logic [7:0] base;
   logic [7:0] b;
   logic [15:0] tail;
   logic       is_strobe;

   always_ff @(posedge clock) begin
      if (reset) begin
         four_ff  <= 1'b0;
         fset8_ff <= RST_FSET_8BIT;
         fset4_ff <= RST_FSET_4BIT;
         entry_ff <= RST_ENTRY;
         disp_ff  <= RST_DISP;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FOUR_BIT:  four_ff  <= csr_wr_data[0];
            CSR_FSET_8BIT: fset8_ff <= csr_wr_data;
            CSR_FSET_4BIT: fset4_ff <= csr_wr_data;
            CSR_ENTRY:     entry_ff <= csr_wr_data;
            CSR_DISP:      disp_ff  <= csr_wr_data;
            default:       ;
         endcase
      end
   end

   always_comb begin
      line_ok_in = 1'b1;
      case (req_payload.line)
         LINE_1:  base = BASE_1;
         LINE_2:  base = BASE_2;
         LINE_3:  base = BASE_3;
         LINE_4:  base = BASE_4;
         default: begin
            base       = BASE_1;
            line_ok_in = 1'b0;
         end
      endcase
      byte_in = (req_payload.opcode == OP_CURSOR) ? base + req_payload.column
                                                  : req_payload.value;
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_payload.opcode;
         line_ok_ff <= line_ok_in;
         mode4_ff   <= four_ff;
         rs_ff      <= req_payload.opcode == OP_CHAR;
         byte_ff    <= byte_in;
      end
   end

   always_comb begin
      case (cmd.src)
         SRC_WAKE8: b = WAKE_BYTE;
         SRC_WAKE4: b = WAKE_NIB;
         SRC_NIB2:  b = NIB_4BIT;
         SRC_FSET:  b = mode4_ff ? fset4_ff : fset8_ff;
         SRC_ENTRY: b = entry_ff;
         SRC_DISP:  b = disp_ff;
         SRC_CLEAR: b = CLEAR_CMD;
         SRC_OFF:   b = OFF_CMD;
         default:   b = byte_ff;
      endcase
      is_strobe = (cmd.src == SRC_WAKE4) || (cmd.src == SRC_NIB2);
      if (is_strobe) begin
         tail = HOLD_STROBE + HOLD_LONG;
      end else if ((cmd.src == SRC_WAKE8) || (cmd.src == SRC_CLEAR)) begin
         tail = HOLD_STROBE + HOLD_SETTLE + HOLD_LONG;
      end else begin
         tail = HOLD_STROBE + HOLD_SETTLE;
      end

      rsp_in.reg_select = (cmd.src == SRC_REQ) ? rs_ff : 1'b0;
      rsp_in.enable     = !cmd.phase[0];
      rsp_in.last       = cmd.last;
      if (cmd.src == SRC_WAIT) begin
         rsp_in.enable    = 1'b0;
         rsp_in.bus_value = 8'h00;
         rsp_in.hold_us   = HOLD_POWER;
      end else if (is_strobe || !mode4_ff) begin
         rsp_in.bus_value = b;
         rsp_in.hold_us   = cmd.phase[0] ? tail : HOLD_STROBE;
      end else begin
         rsp_in.bus_value = cmd.phase[1] ? {4'h0, b[3:0] & NIB_MASK}
                                         : {4'h0, b[7:4] & NIB_MASK};
         rsp_in.hold_us   = (cmd.phase == 2'd3) ? tail : HOLD_STROBE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_ff;
   assign sts.op       = op_ff;
   assign sts.line_ok  = line_ok_ff;
   assign sts.mode4    = mode4_ff;
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

endmodule

[src/char_lcd_interface_sequencer_top.sv]
// Each request is accepted in the idle state, decoded in the decode state, then
// yields one pin state per cycle while the result side keeps up: a 4-bit init
// is 25 pin states; a request with no output goes back to idle. The controller
// sequences one request at a time and stalls the request side until its last
// pin state is placed in the output register. Top level of the sequencer;
// depends on clis_pkg, clis_ctrl and clis_dp.
module char_lcd_interface_sequencer_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [clis_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [clis_pkg::CSR_DATA_W-1:0] csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  clis_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output clis_pkg::rsp_type               rsp_payload
);
   import clis_pkg::*;

   cmd_type cmd;
   sts_type sts;

   clis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   clis_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side not stalled after transfer");

   a_strobe_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.enable |-> rsp_payload.hold_us == HOLD_STROBE)
      else $error("enable high pin state with wrong hold");

   a_last_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |-> !rsp_payload.enable)
      else $error("final pin state leaves enable high");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("emit into occupied output register");

endmodule

[verif/lcd_pin_check_pkg.sv]
`timescale 1ns / 1ps
// Scoreboard for the character LCD sequencer testbench: expands each accepted
// request into the pin states it must produce and checks them in order.
// Depends on clis_pkg.
package lcd_pin_check_pkg;
   import clis_pkg::*;

   class lcd_pin_scoreboard;
      logic       four_bit;
      logic [7:0] fset_8bit;
      logic [7:0] fset_4bit;
      logic [7:0] entry_mode;
      logic [7:0] disp_ctrl;
      rsp_type    pins_due[$];
      rsp_type    burst[$];
      string      faults[$];

      function new();
         four_bit   = 1'b0;
         fset_8bit  = RST_FSET_8BIT;
         fset_4bit  = RST_FSET_4BIT;
         entry_mode = RST_ENTRY;
         disp_ctrl  = RST_DISP;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FOUR_BIT:  four_bit   = data[0];
            CSR_FSET_8BIT: fset_8bit  = data;
            CSR_FSET_4BIT: fset_4bit  = data;
            CSR_ENTRY:     entry_mode = data;
            CSR_DISP:      disp_ctrl  = data;
            default: ;
         endcase
      endfunction

      function void put_pin(logic rs, logic en, logic [7:0] bus, logic [15:0] hold);
         rsp_type p;
         p.reg_select = rs;
         p.enable     = en;
         p.bus_value  = bus;
         p.hold_us    = hold;
         p.last       = 1'b0;
         burst.push_back(p);
      endfunction

      function void pulse_en(logic rs, logic [7:0] bus, logic [15:0] tail);
         put_pin(rs, 1'b1, bus, HOLD_STROBE);
         put_pin(rs, 1'b0, bus, HOLD_STROBE + tail);
      endfunction

      function void push_byte(logic rs, logic [7:0] b, logic [15:0] extra);
         if (four_bit) begin
            pulse_en(rs, {4'h0, b[7:4]}, 16'd0);
            pulse_en(rs, {4'h0, b[3:0]}, HOLD_SETTLE + extra);
         end else begin
            pulse_en(rs, b, HOLD_SETTLE + extra);
         end
      endfunction

      function void push_clear();
         push_byte(1'b0, CLEAR_CMD, HOLD_LONG);
      endfunction

      function void push_init();
         put_pin(1'b0, 1'b0, 8'h00, HOLD_POWER);
         if (four_bit) begin
            for (int i = 0; i < 3; i++) pulse_en(1'b0, WAKE_NIB, HOLD_LONG);
            pulse_en(1'b0, NIB_4BIT, HOLD_LONG);
            push_byte(1'b0, fset_4bit, 16'd0);
         end else begin
            for (int i = 0; i < 3; i++) push_byte(1'b0, WAKE_BYTE, HOLD_LONG);
            push_byte(1'b0, fset_8bit, 16'd0);
         end
         push_byte(1'b0, entry_mode, 16'd0);
         push_byte(1'b0, disp_ctrl, 16'd0);
         push_clear();
      endfunction

      // Expand one accepted request; returns how many pin states it causes.
      function int note_request(req_type r);
         rsp_type tail;
         burst.delete();
         case (r.opcode)
            OP_CMD:  push_byte(1'b0, r.value, 16'd0);
            OP_CHAR: push_byte(1'b1, r.value, 16'd0);
            OP_CURSOR: begin
               case (r.line)
                  LINE_1: push_byte(1'b0, BASE_1 + r.column, 16'd0);
                  LINE_2: push_byte(1'b0, BASE_2 + r.column, 16'd0);
                  LINE_3: push_byte(1'b0, BASE_3 + r.column, 16'd0);
                  LINE_4: push_byte(1'b0, BASE_4 + r.column, 16'd0);
                  default: ;
               endcase
            end
            OP_INIT:  push_init();
            OP_CLEAR: push_clear();
            OP_SHUTDOWN: begin
               push_clear();
               push_byte(1'b0, OFF_CMD, 16'd0);
            end
            default: ;
         endcase
         if (burst.size() > 0) begin
            tail = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
         end
         foreach (burst[i]) pins_due.push_back(burst[i]);
         return burst.size();
      endfunction

      // Compare one received pin state with the oldest one due; collect faults.
      function int check_pin_state(rsp_type got);
         rsp_type want;
         faults.delete();
         if (pins_due.size() == 0) begin
            faults.push_back($sformatf("pin state %h with nothing due", got));
            return faults.size();
         end
         want = pins_due.pop_front();
         if (got.reg_select !== want.reg_select)
            faults.push_back($sformatf("reg_select %b, want %b", got.reg_select,
                                       want.reg_select));
         if (got.enable !== want.enable)
            faults.push_back($sformatf("enable %b, want %b", got.enable, want.enable));
         if (got.bus_value !== want.bus_value)
            faults.push_back($sformatf("bus_value %h, want %h", got.bus_value,
                                       want.bus_value));
         if (got.hold_us !== want.hold_us)
            faults.push_back($sformatf("hold_us %0d, want %0d", got.hold_us, want.hold_us));
         if (got.last !== want.last)
            faults.push_back($sformatf("last %b, want %b", got.last, want.last));
         return faults.size();
      endfunction

      function int outstanding();
         return pins_due.size();
      endfunction
   endclass

endpackage

[verif/char_lcd_interface_sequencer_top_test.sv]
`timescale 1ns / 1ps
// Testbench top for the character LCD sequencer: directed and random requests
// under random stalls, checked against lcd_pin_check_pkg's scoreboard.
// Depends on clis_pkg, lcd_pin_check_pkg and char_lcd_interface_sequencer_top.
module char_lcd_interface_sequencer_top_test;
   import clis_pkg::*;
   import lcd_pin_check_pkg::*;

   localparam int CYCLE_LIMIT     = 900000;
   localparam int RANDOM_ITEMS    = 420;
   localparam int PHASE_ITEMS     = 60;
   localparam int SETTLE_CYCLES   = 30;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int REPORT_CAP      = 100;
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_payload;

   lcd_pin_scoreboard sb;
   int errors;
   int cycles;
   int hold_off_asked;
   bit steady;

   char_lcd_interface_sequencer_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what);
      errors++;
      if (errors <= REPORT_CAP) $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   function automatic int idle_gap();
      if (steady) return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic [7:0] value,
                                        logic [2:0] line, logic [7:0] column);
      req_type r;
      r.opcode = op;
      r.value  = value;
      r.line   = line;
      r.column = column;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      int pick;
      r.value  = 8'($urandom_range(0, 255));
      r.line   = 3'($urandom_range(0, 7));
      r.column = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 30) r.opcode = OP_CMD;
      else if (pick < 58) r.opcode = OP_CHAR;
      else if (pick < 80) begin
         r.opcode = OP_CURSOR;
         if ($urandom_range(0, 4) != 0) r.line = 3'($urandom_range(LINE_1, LINE_4));
      end
      else if (pick < 86) r.opcode = OP_INIT;
      else if (pick < 92) r.opcode = OP_CLEAR;
      else if (pick < 97) r.opcode = OP_SHUTDOWN;
      else r.opcode = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
      return r;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      sb.set_register(idx, data);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic write_registers(input logic [7:0] four, input logic [7:0] f8,
                                  input logic [7:0] f4, input logic [7:0] entry,
                                  input logic [7:0] disp);
      write_csr(CSR_FOUR_BIT, four);
      write_csr(CSR_FSET_8BIT, f8);
      write_csr(CSR_FSET_4BIT, f4);
      write_csr(CSR_ENTRY, entry);
      write_csr(CSR_DISP, disp);
   endtask

   // Hold valid until the transfer, then record what the request must produce.
   task automatic send_request(input req_type r, output int produced);
      int gap;
      gap = idle_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      produced = sb.note_request(r);
   endtask

   // Drop valid and wait for every pin state due; optionally let the block go idle.
   task automatic quiesce(input bit settle);
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : pin_receiver
      int stall_left;
      int hold_left;
      int hold_off_seen;
      int n;
      stall_left    = 0;
      hold_left     = 0;
      hold_off_seen = 0;
      rsp_stall     = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            n = sb.check_pin_state(rsp_payload);
            if (n > 0) begin
               foreach (sb.faults[i]) report_mismatch(sb.faults[i]);
            end
            stall_left = idle_gap();
         end
         @(negedge clock);
         if (hold_off_seen != hold_off_asked) begin
            hold_off_seen = hold_off_asked;
            hold_left     = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      req_type r;
      int produced;
      int made;
      int phase;
      int count;
      errors         = 0;
      hold_off_asked = 0;
      steady         = 1'b0;
      sb             = new();
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_FOUR_BIT;
      csr_wr_data    = '0;
      req_valid      = 1'b0;
      req_payload    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // 8-bit bus at reset settings
      send_request(make_req(OP_CMD, 8'h00, 3'd0, 8'h00), produced);
      send_request(make_req(OP_CMD, 8'hFF, 3'd7, 8'hFF), produced);
      send_request(make_req(OP_CHAR, 8'h00, 3'd0, 8'h00), produced);
      send_request(make_req(OP_CHAR, 8'hFF, 3'd7, 8'hFF), produced);
      send_request(make_req(OP_CHAR, 8'hA5, 3'd2, 8'h5A), produced);
      send_request(make_req(OP_CURSOR, 8'h00, LINE_1, 8'h00), produced);
      send_request(make_req(OP_CURSOR, 8'hFF, LINE_2, 8'h3F), produced);
      send_request(make_req(OP_CURSOR, 8'h00, LINE_3, 8'hFF), produced);
      send_request(make_req(OP_CURSOR, 8'h00, LINE_4, 8'h30), produced);
      // cursor outside lines 1..4 and spare opcodes: no output; init, clear, shutdown
      send_request(make_req(OP_CURSOR, 8'h00, 3'd0, 8'h10), produced);
      send_request(make_req(OP_CURSOR, 8'h00, 3'd5, 8'h10), produced);
      send_request(make_req(OP_CURSOR, 8'h00, 3'd7, 8'hFF), produced);
      send_request(make_req(OP_INIT, 8'h00, 3'd0, 8'h00), produced);
      send_request(make_req(OP_CLEAR, 8'h00, 3'd0, 8'h00), produced);
      send_request(make_req(OP_SHUTDOWN, 8'h00, 3'd0, 8'h00), produced);
      send_request(make_req(OP_SPARE_LO, 8'hFF, 3'd1, 8'h01), produced);
      send_request(make_req(OP_SPARE_HI, 8'h81, 3'd4, 8'h80), produced);
      quiesce(1'b1);

      // 4-bit bus: nibble transfers, high nibble first
      write_csr(CSR_FOUR_BIT, 8'h01);
      send_request(make_req(OP_INIT, 8'h00, 3'd0, 8'h00), produced);
      send_request(make_req(OP_CMD, 8'h5A, 3'd0, 8'h00), produced);
      send_request(make_req(OP_CHAR, 8'hC3, 3'd0, 8'h00), produced);
      send_request(make_req(OP_CURSOR, 8'h00, LINE_4, 8'hFF), produced);
      send_request(make_req(OP_CLEAR, 8'h00, 3'd0, 8'h00), produced);
      send_request(make_req(OP_SHUTDOWN, 8'h00, 3'd0, 8'h00), produced);

      made  = 0;
      phase = 0;
      while (made < RANDOM_ITEMS) begin
         quiesce(1'b1);
         steady = (phase % 4 == 3);
         case (phase % 4)
            0: write_registers(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            1: write_registers(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
            default: write_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)));
         endcase
         count = 0;
         while (count < PHASE_ITEMS && made < RANDOM_ITEMS) begin
            if (phase % 4 == 2 && count == 10) hold_off_asked++;
            r = random_request();
            send_request(r, produced);
            if (produced > 0) begin
               count++;
               made++;
            end
            if ($urandom_range(0, 39) == 0) quiesce(1'b0);
         end
         phase++;
      end

      quiesce(1'b1);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
src/clis_pkg.sv
src/clis_ctrl.sv
src/clis_dp.sv
src/char_lcd_interface_sequencer_top.sv
verif/lcd_pin_check_pkg.sv
verif/char_lcd_interface_sequencer_top_test.sv
